// ===== rtl/core/tli_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tli_pkg - shared types and constants of the table linear interpolator
// Word widths, operation and status codes, and the request and response
// bundles between the sequencer and the multiply/divide unit.
// ----------------------------------------------------------------------------
package tli_pkg;

  // default number of breakpoints
  localparam int TABLE_DEPTH_DEF = 64;

  // field widths
  localparam int OP_W   = 2;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 3;
  localparam int IN_W   = 2 * VAL_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_BELOW = 3'd1;
  localparam logic [ST_W-1:0] ST_ABOVE = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL  = 3'd4;

  // multiply/divide unit step counts
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 33;

  // request to the multiply/divide unit: q = (mag * dn + dd/2) / dd
  typedef struct packed {
    logic        start;
    logic [32:0] mag;
    logic [31:0] dn;
    logic [31:0] dd;
  } mdu_req_t;

  // response from the multiply/divide unit
  typedef struct packed {
    logic        done;
    logic [32:0] quo;
  } mdu_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/table_linear_interpolator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// table_linear_interpolator - piecewise linear interpolation over a table
// Breakpoint table in a single-port ram, linear scan, and an iterative
// multiply/divide unit for the interpolation in signed Q16.16.
// ----------------------------------------------------------------------------
// Append, clear, unused codes and a query against an empty table finish in
// the cycle the word is accepted and the result word appears in the cycle
// after. A query scans the breakpoints one at a time through the single ram
// port (address, then registered data); an interpolated result then goes
// through the shift-add multiply (32 steps), rounding add and restoring
// divide (33 steps) in the shared unit. Only one word is in work at a time;
// a new word is taken once the result register is free or being emptied.
// The table is not cleared at reset: only entries below the fill count are
// ever read.
module table_linear_interpolator #(
  parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // input words
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [tli_pkg::IN_W-1:0]  s_tdata,   // point_x[31:0], point_y[63:32]
  input  logic [tli_pkg::OP_W-1:0]  s_tuser,   // op[1:0]
  // result words
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [tli_pkg::VAL_W-1:0] m_tdata,   // value_y[31:0]
  output logic [tli_pkg::ST_W-1:0]  m_tuser    // status[2:0]
);
  import tli_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_CALC  = 3'd4;

  logic [2:0]        state;
  logic [CW-1:0]     count;
  logic [AW-1:0]     idx;
  logic signed [31:0] qx;
  logic signed [31:0] x0;
  logic signed [31:0] y0;
  logic signed [31:0] y1;
  logic signed [32:0] dy;
  logic [31:0]       dn;
  logic [31:0]       dd;

  logic               accept;
  logic               fast_done;
  logic [OP_W-1:0]    in_op;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic               full;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [IN_W-1:0]    ram_rdata;
  logic signed [31:0] rd_x;
  logic signed [31:0] rd_y;
  logic signed [32:0] dy_w;
  mdu_req_t           req;
  mdu_rsp_t           rsp;
  logic signed [34:0] ysum;
  logic [31:0]        ysat;

  // input side
  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign in_op    = s_tuser;
  assign in_x     = s_tdata[31:0];
  assign in_y     = s_tdata[63:32];
  assign full     = (count == CW'(TABLE_DEPTH));

  // word that finishes in its accept cycle loads the result register
  assign fast_done = accept && ((in_op != OP_QUERY) || (count == '0));

  // breakpoint store, {y, x} per entry
  assign ram_we   = accept && (in_op == OP_APPEND) && !full;
  assign ram_addr = (state == S_IDLE) ? count[AW-1:0] : idx;

  tli_ram #(
    .WIDTH (IN_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({in_y, in_x}),
    .rdata (ram_rdata)
  );

  assign rd_x = ram_rdata[31:0];
  assign rd_y = ram_rdata[63:32];
  assign dy_w = {rd_y[31], rd_y} - {y0[31], y0};

  // multiply/divide request
  assign req.start = (state == S_PREP);
  assign req.mag   = dy[32] ? (~dy + 33'sd1) : dy;
  assign req.dn    = dn;
  assign req.dd    = dd;

  tli_mdu u_mdu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // final step toward y0 and saturation
  always_comb begin
    if (dy[32]) begin
      ysum = {{3{y1[31]}}, y1} + $signed({2'b0, rsp.quo});
    end else begin
      ysum = {{3{y1[31]}}, y1} - $signed({2'b0, rsp.quo});
    end
    if (!ysum[34] && (|ysum[33:31])) begin
      ysat = 32'h7FFF_FFFF;
    end else if (ysum[34] && !(&ysum[33:31])) begin
      ysat = 32'h8000_0000;
    end else begin
      ysat = ysum[31:0];
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !fast_done) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_op)
              OP_APPEND: begin
                m_tvalid <= 1'b1;
                m_tdata  <= '0;
                m_tuser  <= full ? ST_FULL : ST_OK;
                if (!full) begin
                  count <= count + CW'(1);
                end
              end
              OP_QUERY: begin
                if (count == '0) begin
                  m_tvalid <= 1'b1;
                  m_tdata  <= '0;
                  m_tuser  <= ST_EMPTY;
                end else begin
                  idx   <= '0;
                  qx    <= in_x;
                  state <= S_FETCH;
                end
              end
              OP_CLEAR: begin
                count    <= '0;
                m_tvalid <= 1'b1;
                m_tdata  <= '0;
                m_tuser  <= ST_OK;
              end
              default: begin
                m_tvalid <= 1'b1;
                m_tdata  <= '0;
                m_tuser  <= ST_OK;
              end
            endcase
          end
        end
        S_FETCH: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (qx > rd_x) begin
            if (CW'(idx) + CW'(1) == count) begin
              m_tvalid <= 1'b1;
              m_tdata  <= '0;
              m_tuser  <= ST_ABOVE;
              state    <= S_IDLE;
            end else begin
              idx   <= idx + AW'(1);
              x0    <= rd_x;
              y0    <= rd_y;
              state <= S_FETCH;
            end
          end else if (idx == '0) begin
            // at or below the first breakpoint
            m_tvalid <= 1'b1;
            m_tdata  <= (qx < rd_x) ? 32'd0 : rd_y;
            m_tuser  <= (qx < rd_x) ? ST_BELOW : ST_OK;
            state    <= S_IDLE;
          end else begin
            y1    <= rd_y;
            dy    <= dy_w;
            dn    <= rd_x - qx;
            dd    <= rd_x - x0;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          state <= S_CALC;
        end
        S_CALC: begin
          if (rsp.done) begin
            m_tvalid <= 1'b1;
            m_tdata  <= ysat;
            m_tuser  <= ST_OK;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // fill count never passes the table size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table size");

  // the scan only looks at filled entries
  a_scan_filled: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (CW'(idx) < count))
    else $error("scan read past fill count");

  // the unit only finishes while the sequencer waits for it
  a_done_calc: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_CALC))
    else $error("multiply/divide done outside calc");

  // result register is empty while a query is in work
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH || state == S_CMP || state == S_PREP || state == S_CALC)
      |-> !m_tvalid)
    else $error("result word pending during query");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
    else $error("non-zero value with error status");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/tli_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tli_ram - generic single-port ram
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module tli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/tli_mdu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tli_mdu - iterative multiply/divide unit
// Shift-add multiply, rounding offset add, then restoring division; the
// multiply and divide steps go through one shared 34-bit adder/subtractor.
// ----------------------------------------------------------------------------
module tli_mdu (
  input  logic             clk,
  input  logic             rst,
  input  tli_pkg::mdu_req_t req,
  output tli_pkg::mdu_rsp_t rsp
);
  import tli_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MUL  = 3'd1;
  localparam logic [2:0] PH_NUM  = 3'd2;
  localparam logic [2:0] PH_DIV  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  logic [2:0]       phase;
  logic [CNT_W-1:0] cnt;
  logic [32:0]      mag_r;
  logic [31:0]      dd_r;
  logic [65:0]      prod;
  logic [32:0]      rem;
  logic [32:0]      qsh;

  logic [33:0] op_a;
  logic [33:0] op_b;
  logic        sub;
  logic [33:0] sum;
  logic [63:0] num;

  // shared adder: accumulate in multiply, trial subtract in divide
  always_comb begin
    if (phase == PH_DIV) begin
      op_a = {1'b0, rem[31:0], qsh[32]};
      op_b = {2'b0, dd_r};
      sub  = 1'b1;
    end else begin
      op_a = prod[65:32];
      op_b = prod[0] ? {1'b0, mag_r} : 34'd0;
      sub  = 1'b0;
    end
    sum = op_a + (sub ? ~op_b : op_b) + {33'd0, sub};
  end

  // product plus half the divisor, for round to nearest
  assign num = prod[63:0] + {33'd0, dd_r[31:1]};

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (req.start) begin
            mag_r <= req.mag;
            dd_r  <= req.dd;
            prod  <= {34'd0, req.dn};
            cnt   <= '0;
            phase <= PH_MUL;
          end
        end
        PH_MUL: begin
          prod <= {1'b0, sum, prod[31:1]};
          cnt  <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(MUL_STEPS - 1)) begin
            phase <= PH_NUM;
          end
        end
        PH_NUM: begin
          // quotient is below 2^33, so the top bits start below the divisor
          rem   <= {2'b0, num[63:33]};
          qsh   <= num[32:0];
          cnt   <= '0;
          phase <= PH_DIV;
        end
        PH_DIV: begin
          rem  <= sum[33] ? op_a[32:0] : sum[32:0];
          qsh  <= {qsh[31:0], ~sum[33]};
          cnt  <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            phase <= PH_DONE;
          end
        end
        PH_DONE: begin
          phase <= PH_IDLE;
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = (phase == PH_DONE);
  assign rsp.quo  = qsh;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - regression bench for the table linear interpolator
// A queue of input words is driven into the block under random idling and
// one long output hold-off. Each accepted word is run through a local
// breakpoint table model and every result word is checked against it.
// ----------------------------------------------------------------------------
module tb;
  import tli_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam longint Q_MIN_L = -64'sd2147483648;
  localparam longint Q_MAX_L = 64'sd2147483647;
  localparam int RANDOM_WORDS = 1300;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 1200000;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [31:0]     x;
    logic [31:0]     y;
  } tli_word_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic [ST_W-1:0]  status;
  } tli_result_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;    // point_x[31:0], point_y[63:32]
  logic [OP_W-1:0]  s_tuser = '0;    // op[1:0]
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [VAL_W-1:0] m_tdata;         // value_y[31:0]
  logic [ST_W-1:0]  m_tuser;         // status[2:0]

  tli_word_t   pending_words[$];
  tli_result_t due_results[$];
  int          gen_x[$];

  // model copy of the breakpoint table
  logic signed [31:0] tab_x [TABLE_DEPTH];
  logic signed [31:0] tab_y [TABLE_DEPTH];
  int                 fill_cnt = 0;

  int     word_cnt = 0;
  int     result_cnt = 0;
  int     err_cnt = 0;
  int     total_words = 1;
  int     hold_at = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;
  longint cycle_cnt = 0;

  table_linear_interpolator #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // table update and interpolation for one accepted word
  function automatic tli_result_t predict_lookup(logic [OP_W-1:0] op, logic signed [31:0] px,
                                                 logic signed [31:0] py);
    tli_result_t r;
    int          i;
    longint      y1, dy, yv;
    logic [63:0] mag, dn, dd, q;
    r.value = '0;
    r.status = ST_OK;
    case (op)
      OP_APPEND: begin
        if (fill_cnt >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tab_x[fill_cnt] = px;
          tab_y[fill_cnt] = py;
          fill_cnt++;
        end
      end
      OP_CLEAR: begin
        fill_cnt = 0;
      end
      OP_QUERY: begin
        if (fill_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          i = 0;
          while (i < fill_cnt && px > tab_x[i]) i++;
          if (i >= fill_cnt) begin
            r.status = ST_ABOVE;
          end else if (i == 0) begin
            // on the first x the first y comes back, below it is out of range
            if (px < tab_x[0]) r.status = ST_BELOW;
            else r.value = tab_y[0];
          end else begin
            y1 = longint'(tab_y[i]);
            dy = y1 - longint'(tab_y[i-1]);
            dn = longint'(tab_x[i]) - longint'(px);
            dd = longint'(tab_x[i]) - longint'(tab_x[i-1]);
            mag = (dy < 0) ? -dy : dy;
            // rounded to nearest, ties away from zero
            q = (mag * dn + dd / 2) / dd;
            yv = (dy >= 0) ? y1 - longint'(q) : y1 + longint'(q);
            if (yv > Q_MAX_L) r.value = Q_MAX;
            else if (yv < Q_MIN_L) r.value = Q_MIN;
            else r.value = yv[31:0];
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic int idle_pct(bit rx_side);
    if (word_cnt < total_words / 3) return rx_side ? 75 : 19;
    if (word_cnt < 2 * total_words / 3) return rx_side ? 19 : 75;
    return 0;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s at result %0d, got %h want %h", what, result_cnt, got, want);
    err_cnt++;
  endtask

  task automatic push_word(logic [OP_W-1:0] op, logic [31:0] x, logic [31:0] y);
    tli_word_t w;
    w.op = op;
    w.x = x;
    w.y = y;
    pending_words.push_back(w);
  endtask

  // clear, then append n breakpoints sorted by x
  task automatic build_table(int n, bit wide);
    int k, j, v, step_max;
    gen_x.delete();
    push_word(OP_CLEAR, $urandom, $urandom);
    if (wide) begin
      for (k = 0; k < n; k++) begin
        gen_x.push_back(int'($urandom));
        j = gen_x.size() - 1;
        while (j > 0 && gen_x[j-1] > gen_x[j]) begin
          v = gen_x[j];
          gen_x[j] = gen_x[j-1];
          gen_x[j-1] = v;
          j--;
        end
      end
    end else begin
      case ($urandom_range(2, 0))
        0: step_max = 4;
        1: step_max = 65536;
        default: step_max = 1 << 20;
      endcase
      v = int'($urandom_range(32'h7000_0000, 0)) - 32'h3800_0000;
      for (k = 0; k < n; k++) begin
        v = v + int'($urandom_range(step_max, 0));
        gen_x.push_back(v);
      end
    end
    for (k = 0; k < n; k++) begin
      if (wide || $urandom_range(1, 0) == 0) push_word(OP_APPEND, gen_x[k], $urandom);
      else push_word(OP_APPEND, gen_x[k], int'($urandom_range(1 << 21, 0)) - (1 << 20));
    end
  endtask

  // query between, on, below, above or anywhere around the built table
  task automatic push_query();
    longint      lo, hi;
    int          n, j, sel;
    logic [31:0] span;
    n = gen_x.size();
    sel = $urandom_range(99, 0);
    if (sel < 50 && n > 1) begin
      j = $urandom_range(n - 1, 1);
      lo = gen_x[j-1];
      hi = gen_x[j];
    end else if (sel < 65) begin
      j = $urandom_range(n - 1, 0);
      lo = gen_x[j];
      hi = gen_x[j];
    end else if (sel < 75) begin
      lo = Q_MIN_L;
      hi = longint'(gen_x[0]) - 1;
    end else if (sel < 85) begin
      lo = longint'(gen_x[n-1]) + 1;
      hi = Q_MAX_L;
    end else begin
      lo = Q_MIN_L;
      hi = Q_MAX_L;
    end
    if (lo > Q_MAX_L) lo = Q_MAX_L;
    if (hi < lo) hi = lo;
    span = 32'(hi - lo);
    push_word(OP_QUERY, 32'(lo + longint'($urandom_range(span, 0))), $urandom);
  endtask

  task automatic build_stimulus();
    int sel, n, target;
    // directed words
    push_word(OP_QUERY, 32'h0, 32'h0);
    push_word(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_word(OP_CLEAR, 32'h0, 32'h0);
    push_word(OP_APPEND, Q_MIN, Q_MAX);
    push_word(OP_QUERY, Q_MIN, 32'h0);
    push_word(OP_APPEND, Q_MAX, Q_MIN);
    push_word(OP_QUERY, 32'h0, 32'h0);
    push_word(OP_QUERY, Q_MAX, 32'h0);
    push_word(OP_QUERY, Q_MAX - 1, 32'h0);
    push_word(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_word(OP_QUERY, 32'h5, 32'h0);
    push_word(OP_APPEND, 32'h0001_0000, 32'h0001_0000);
    push_word(OP_APPEND, 32'h0003_0000, 32'h0005_0000);
    push_word(OP_QUERY, 32'h0000_FFFF, 32'h0);
    push_word(OP_QUERY, 32'h0003_0001, 32'h0);
    push_word(OP_QUERY, 32'h0002_0000, 32'h0);
    push_word(OP_QUERY, 32'h0001_8000, 32'h0);
    // rising and falling half-step ties
    push_word(OP_APPEND, 32'h0003_0002, 32'h0005_0001);
    push_word(OP_QUERY, 32'h0003_0001, 32'h0);
    push_word(OP_APPEND, 32'h0003_0004, 32'h0005_0000);
    push_word(OP_QUERY, 32'h0003_0003, 32'h0);
    push_word(OP_CLEAR, 32'h0, 32'h0);
    push_word(OP_QUERY, 32'h0, 32'h0);
    // random sequences, mostly sorted tables with queries, some noise
    target = pending_words.size() + RANDOM_WORDS;
    while (pending_words.size() < target) begin
      sel = $urandom_range(99, 0);
      if (sel < 8) begin
        repeat ($urandom_range(8, 1)) begin
          push_word(OP_W'($urandom_range(3, 0)), $urandom, $urandom);
        end
      end else begin
        sel = $urandom_range(99, 0);
        if (sel < 70) n = $urandom_range(16, 1);
        else if (sel < 90) n = $urandom_range(TABLE_DEPTH - 1, 17);
        else n = TABLE_DEPTH;
        build_table(n, 1'($urandom_range(1, 0)));
        if (n == TABLE_DEPTH) begin
          repeat ($urandom_range(3, 1)) push_word(OP_APPEND, $urandom, $urandom);
        end
        repeat ($urandom_range(16, 4)) push_query();
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        due_results.push_back(predict_lookup(s_tuser, s_tdata[31:0], s_tdata[63:32]));
        word_cnt <= word_cnt + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99, 0) >= idle_pct(1'b0)) begin
          s_tvalid <= 1'b1;
          s_tdata <= {pending_words[0].y, pending_words[0].x};
          s_tuser <= pending_words[0].op;
          pending_words.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && word_cnt >= hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // output ready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && ($urandom_range(99, 0) >= idle_pct(1'b1));
    end
  end

  // result monitor
  always @(posedge clk) begin
    tli_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result word with none due", m_tdata, 32'h0);
      end else begin
        want = due_results.pop_front();
        if (m_tdata !== want.value) report_mismatch("value_y", m_tdata, want.value);
        if (m_tuser !== want.status) report_mismatch("status", 32'(m_tuser), 32'(want.status));
      end
      result_cnt <= result_cnt + 1;
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // sequence and end of run
  initial begin
    build_stimulus();
    total_words = pending_words.size();
    hold_at = 2 * total_words / 3 + 40;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_words.size() != 0 || s_tvalid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
